@@ rtl/dot_edge_list_parser_defines.svh @@
// Assertion macros shared by the edge-list parser checkers.
// No dependencies; included by files that carry concurrent assertions.
`ifndef DOT_EDGE_LIST_PARSER_DEFINES_SVH
`define DOT_EDGE_LIST_PARSER_DEFINES_SVH

// same-cycle implication, disabled while reset is held
`define DELP_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled while reset is held
`define DELP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/delp_pkg.sv @@
// Shared types, codes and helper functions of the edge-list parser.
// No dependencies; used by delp_out_if, the parser, queue, top and checker.
`timescale 1ns / 1ps
`default_nettype none

package delp_pkg;

  localparam int LINE_BUFFER_DEF = 1024;
  localparam int ID_WIDTH_DEF    = 24;
  localparam int RES_DEPTH       = 4;

  localparam logic OP_CHAR      = 1'b0;
  localparam logic OP_END       = 1'b1;
  localparam logic KIND_EDGE    = 1'b0;
  localparam logic KIND_SUMMARY = 1'b1;

  localparam logic [7:0] CH_NUL   = 8'd0;
  localparam logic [7:0] CH_NL    = 8'd10;
  localparam logic [7:0] CH_SPACE = 8'd32;
  localparam logic [7:0] CH_DASH  = 8'h2d;
  localparam logic [7:0] CH_GT    = 8'h3e;
  localparam logic [7:0] CH_D     = 8'h64;
  localparam logic [7:0] CH_G     = 8'h67;
  localparam logic [7:0] CH_S     = 8'h73;

  localparam logic [47:0] KW_STRICT  = "strict";
  localparam logic [55:0] KW_DIGRAPH = "digraph";
  localparam logic [39:0] KW_GRAPH   = "graph";
  localparam logic [2:0]  KW_STRICT_LEN  = 3'd6;
  localparam logic [2:0]  KW_DIGRAPH_LEN = 3'd7;
  localparam logic [2:0]  KW_GRAPH_LEN   = 3'd5;

  typedef enum logic [10:0] {
    PH_LEAD        = 11'b000_0000_0001,
    PH_STRICT      = 11'b000_0000_0010,
    PH_POST_STRICT = 11'b000_0000_0100,
    PH_DIGRAPH     = 11'b000_0000_1000,
    PH_GRAPH       = 11'b000_0001_0000,
    PH_FIRST_NUM   = 11'b000_0010_0000,
    PH_AFTER_ID    = 11'b000_0100_0000,
    PH_DASH        = 11'b000_1000_0000,
    PH_PRE_NUM     = 11'b001_0000_0000,
    PH_NEXT_NUM    = 11'b010_0000_0000,
    PH_IGNORE      = 11'b100_0000_0000
  } phase_t;

  // what the parser hands to the result queue for one request
  typedef struct packed {
    logic edge_vld;
    logic sum_vld;
    logic directed;
    logic seen;
  } push_t;

  function automatic logic is_blank(input logic [7:0] c);
    return (c == CH_SPACE) || (c >= 8'd9 && c <= 8'd13);
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= 8'h30) && (c <= 8'h39);
  endfunction

  function automatic logic [2:0] kw_len(input phase_t ph);
    logic [2:0] len;
    case (ph)
      PH_STRICT:  len = KW_STRICT_LEN;
      PH_DIGRAPH: len = KW_DIGRAPH_LEN;
      PH_GRAPH:   len = KW_GRAPH_LEN;
      default:    len = 3'd0;
    endcase
    return len;
  endfunction

  function automatic logic [7:0] kw_char(input phase_t ph, input logic [2:0] pos);
    logic [7:0] c;
    c = 8'd0;
    case (ph)
      PH_STRICT: begin
        if (pos < KW_STRICT_LEN) c = KW_STRICT[8*(5 - int'(pos)) +: 8];
      end
      PH_DIGRAPH: begin
        if (pos < KW_DIGRAPH_LEN) c = KW_DIGRAPH[8*(6 - int'(pos)) +: 8];
      end
      PH_GRAPH: begin
        if (pos < KW_GRAPH_LEN) c = KW_GRAPH[8*(4 - int'(pos)) +: 8];
      end
      default: c = 8'd0;
    endcase
    return c;
  endfunction

endpackage

`default_nettype wire

@@ rtl/delp_in_if.sv @@
// Text request channel: opcode and character with a valid/ready handshake.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

interface delp_in_if;
  logic       valid;
  logic       ready;
  logic       opcode;
  logic [7:0] ch;

  modport source (output valid, output opcode, output ch, input ready);
  modport sink   (input valid, input opcode, input ch, output ready);
endinterface

`default_nettype wire

@@ rtl/delp_out_if.sv @@
// Result channel: edges and end summaries with a valid/ready handshake.
// Depends on delp_pkg for the default id width.
`timescale 1ns / 1ps
`default_nettype none

interface delp_out_if #(
  parameter int ID_WIDTH = delp_pkg::ID_WIDTH_DEF
);
  logic                valid;
  logic                ready;
  logic                kind;
  logic [ID_WIDTH-1:0] src_id;
  logic [ID_WIDTH-1:0] dst_id;
  logic                is_directed;
  logic [ID_WIDTH:0]   vertex_count;
  logic                valid_res;
  logic                last;

  modport source (output valid, output kind, output src_id, output dst_id,
                  output is_directed, output vertex_count, output valid_res,
                  output last, input ready);
  modport sink   (input valid, input kind, input src_id, input dst_id,
                  input is_directed, input vertex_count, input valid_res,
                  input last, output ready);
endinterface

`default_nettype wire

@@ rtl/dot_edge_list_parser.sv @@
// Top level of the edge-list parser: parser state machine and result queue.
// Depends on delp_pkg, delp_in_if, delp_out_if, delp_parser, delp_res_fifo.
//
//   channel   dir  handshake          payload
//   in_ch     in   valid / ready      opcode, ch
//   out_res   out  valid / ready      kind, src_id, dst_id, is_directed,
//                                     vertex_count, valid_res, last
//
// One request per cycle while in_ch.ready is high; each request is parsed in the cycle it is accepted.
// A character request gives at most one result, an end request up to two.
// Results wait in a four-entry queue; in_ch.ready drops while fewer than two
// entries are free, so requests stall once three results wait on out_res.
// Synchronous reset returns the parser to line start and empties the queue.
`timescale 1ns / 1ps
`default_nettype none

module dot_edge_list_parser #(
  parameter int LINE_BUFFER = delp_pkg::LINE_BUFFER_DEF,
  parameter int ID_WIDTH    = delp_pkg::ID_WIDTH_DEF
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  delp_in_if.sink    in_ch,
  delp_out_if.source out_res
);

  localparam int EW = 3 * ID_WIDTH + 5;

  delp_pkg::push_t     push;
  logic                in_acc, space2, rd_vld;
  logic [ID_WIDTH-1:0] edge_src, edge_dst;
  logic [ID_WIDTH:0]   sum_count;
  logic [EW-1:0]       edge_ent, sum_ent, push_d0, rd_data;
  logic [1:0]          push_cnt;

  assign in_ch.ready = space2;
  assign in_acc      = in_ch.valid && space2;

  delp_parser #(
    .LINE_BUFFER (LINE_BUFFER),
    .ID_WIDTH    (ID_WIDTH)
  ) u_parser (
    .clk       (clk),
    .rst_n     (rst_n),
    .accept    (in_acc),
    .opcode    (in_ch.opcode),
    .ch        (in_ch.ch),
    .push      (push),
    .edge_src  (edge_src),
    .edge_dst  (edge_dst),
    .sum_count (sum_count)
  );

  assign edge_ent = {delp_pkg::KIND_EDGE, edge_src, edge_dst, push.directed,
                     {(ID_WIDTH + 1){1'b0}}, 1'b0, !push.sum_vld};
  assign sum_ent  = {delp_pkg::KIND_SUMMARY, {ID_WIDTH{1'b0}}, {ID_WIDTH{1'b0}},
                     push.directed, sum_count, push.seen, 1'b1};
  assign push_d0  = push.edge_vld ? edge_ent : sum_ent;
  assign push_cnt = {push.edge_vld && push.sum_vld, push.edge_vld ^ push.sum_vld};

  delp_res_fifo #(
    .WIDTH (EW),
    .DEPTH (delp_pkg::RES_DEPTH)
  ) u_res_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push_cnt (push_cnt),
    .push_d0  (push_d0),
    .push_d1  (sum_ent),
    .space2   (space2),
    .pop      (rd_vld && out_res.ready),
    .rd_vld   (rd_vld),
    .rd_data  (rd_data)
  );

  assign out_res.valid = rd_vld;
  assign {out_res.kind, out_res.src_id, out_res.dst_id, out_res.is_directed,
          out_res.vertex_count, out_res.valid_res, out_res.last} = rd_data;

endmodule

`default_nettype wire

@@ rtl/delp_res_fifo.sv @@
// Small result queue that takes up to two entries per cycle and gives one.
// Depends on delp_pkg for the default depth.
`timescale 1ns / 1ps
`default_nettype none

module delp_res_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = delp_pkg::RES_DEPTH
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic [1:0]       push_cnt,
  input  wire logic [WIDTH-1:0] push_d0,
  input  wire logic [WIDTH-1:0] push_d1,
  output logic                  space2,
  input  wire logic             pop,
  output logic                  rd_vld,
  output logic [WIDTH-1:0]      rd_data
);

  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PW-1:0]    wr_ptr_r, wr_ptr_nxt, wr_ptr_p1, rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]    cnt_r, cnt_nxt;

  function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
    return (p == PW'(DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  assign wr_ptr_p1 = ptr_inc(wr_ptr_r);
  assign rd_vld    = (cnt_r != '0);
  assign rd_data   = mem_r[rd_ptr_r];
  assign space2    = (cnt_r <= CW'(DEPTH - 2));

  always_comb begin
    case (push_cnt)
      2'd1:    wr_ptr_nxt = wr_ptr_p1;
      2'd2:    wr_ptr_nxt = ptr_inc(wr_ptr_p1);
      default: wr_ptr_nxt = wr_ptr_r;
    endcase
    rd_ptr_nxt = pop ? ptr_inc(rd_ptr_r) : rd_ptr_r;
    cnt_nxt    = cnt_r + CW'(push_cnt) - CW'(pop);
  end

  always_ff @(posedge clk) begin
    if (push_cnt != 2'd0) mem_r[wr_ptr_r] <= push_d0;
    if (push_cnt == 2'd2) mem_r[wr_ptr_p1] <= push_d1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

endmodule

`default_nettype wire

@@ rtl/delp_parser.sv @@
// Line parser state machine: keywords, id chains and the largest id.
// Depends on delp_pkg for phases, character codes and the push struct.
`timescale 1ns / 1ps
`default_nettype none

module delp_parser #(
  parameter int LINE_BUFFER = delp_pkg::LINE_BUFFER_DEF,
  parameter int ID_WIDTH    = delp_pkg::ID_WIDTH_DEF
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                accept,
  input  wire logic                opcode,
  input  wire logic [7:0]          ch,
  output delp_pkg::push_t          push,
  output logic [ID_WIDTH-1:0]      edge_src,
  output logic [ID_WIDTH-1:0]      edge_dst,
  output logic [ID_WIDTH:0]        sum_count
);

  localparam int LPW = $clog2(LINE_BUFFER);
  localparam int PW  = ID_WIDTH + 5;

  delp_pkg::phase_t    ph_r, ph_nxt;
  logic [2:0]          kw_pos_r, kw_nxt;
  logic [LPW-1:0]      line_pos_r, lp_nxt;
  logic [ID_WIDTH:0]   acc_r, acc_nxt;
  logic [ID_WIDTH-1:0] prev_r, prev_nxt, max_r, max_nxt;
  logic                seen_r, seen_nxt, dir_r, dir_nxt, known_r, known_nxt;

  logic [ID_WIDTH-1:0] acc_id, fin_max;
  logic                is_num, fin_ok, fin_edge, blank, digit, line_full, kw_hit;
  logic [2:0]          kw_total;
  logic [PW-1:0]       prod;
  logic [ID_WIDTH:0]   digit_val, acc_sat;

  assign acc_id    = acc_r[ID_WIDTH-1:0];
  assign is_num    = (ph_r == delp_pkg::PH_FIRST_NUM) || (ph_r == delp_pkg::PH_NEXT_NUM);
  assign fin_ok    = is_num && !acc_r[ID_WIDTH];
  assign fin_edge  = fin_ok && (ph_r == delp_pkg::PH_NEXT_NUM);
  assign fin_max   = (fin_ok && (!seen_r || acc_id > max_r)) ? acc_id : max_r;
  assign blank     = delp_pkg::is_blank(ch);
  assign digit     = delp_pkg::is_digit(ch);
  assign line_full = (line_pos_r >= LPW'(LINE_BUFFER - 1));
  assign kw_total  = delp_pkg::kw_len(ph_r);
  assign kw_hit    = (kw_pos_r < kw_total) && (ch == delp_pkg::kw_char(ph_r, kw_pos_r));
  assign digit_val = {{(ID_WIDTH - 3){1'b0}}, ch[3:0]};
  assign acc_sat   = {1'b1, {ID_WIDTH{1'b0}}};
  assign prod      = {acc_r, 3'b000} + {2'b00, acc_r, 1'b0} + {4'b0000, digit_val};

  assign edge_src  = prev_r;
  assign edge_dst  = acc_id;
  assign sum_count = (seen_r || fin_ok) ? ({1'b0, fin_max} + 1'b1) : '0;

  always_comb begin
    ph_nxt    = ph_r;
    kw_nxt    = kw_pos_r;
    lp_nxt    = line_pos_r;
    acc_nxt   = acc_r;
    prev_nxt  = prev_r;
    max_nxt   = max_r;
    seen_nxt  = seen_r;
    dir_nxt   = dir_r;
    known_nxt = known_r;
    push.edge_vld = 1'b0;
    push.sum_vld  = 1'b0;
    push.directed = dir_r;
    push.seen     = seen_r || fin_ok;
    if (accept) begin
      if (opcode == delp_pkg::OP_END) begin
        push.edge_vld = fin_edge;
        push.sum_vld  = 1'b1;
        ph_nxt    = delp_pkg::PH_LEAD;
        kw_nxt    = '0;
        lp_nxt    = '0;
        acc_nxt   = '0;
        prev_nxt  = '0;
        max_nxt   = '0;
        seen_nxt  = 1'b0;
        dir_nxt   = 1'b1;
        known_nxt = 1'b0;
      end else if (ch == delp_pkg::CH_NL || line_full || ch == delp_pkg::CH_NUL) begin
        // close an open id, then restart or drop the rest of the line
        push.edge_vld = fin_edge;
        if (fin_ok) begin
          prev_nxt = acc_id;
          max_nxt  = fin_max;
          seen_nxt = 1'b1;
        end
        if (ch == delp_pkg::CH_NL) begin
          ph_nxt = delp_pkg::PH_LEAD;
          lp_nxt = '0;
          kw_nxt = '0;
        end else begin
          ph_nxt = delp_pkg::PH_IGNORE;
        end
      end else begin
        lp_nxt = line_pos_r + 1'b1;
        case (ph_r)
          delp_pkg::PH_LEAD, delp_pkg::PH_POST_STRICT: begin
            if (!blank) begin
              kw_nxt = 3'd1;
              if (ch == delp_pkg::CH_D) begin
                ph_nxt = delp_pkg::PH_DIGRAPH;
              end else if (ch == delp_pkg::CH_G) begin
                ph_nxt = delp_pkg::PH_GRAPH;
              end else if (ch == delp_pkg::CH_S && ph_r == delp_pkg::PH_LEAD) begin
                ph_nxt = delp_pkg::PH_STRICT;
              end else if (digit) begin
                acc_nxt = digit_val;
                ph_nxt  = delp_pkg::PH_FIRST_NUM;
              end else begin
                ph_nxt = delp_pkg::PH_IGNORE;
              end
            end
          end
          delp_pkg::PH_STRICT, delp_pkg::PH_DIGRAPH, delp_pkg::PH_GRAPH: begin
            if (kw_hit) begin
              kw_nxt = kw_pos_r + 1'b1;
              if (kw_pos_r + 3'd1 == kw_total) begin
                if (ph_r == delp_pkg::PH_STRICT) begin
                  ph_nxt = delp_pkg::PH_POST_STRICT;
                end else begin
                  dir_nxt   = (ph_r == delp_pkg::PH_DIGRAPH);
                  known_nxt = 1'b1;
                  ph_nxt    = delp_pkg::PH_IGNORE;
                end
              end
            end else begin
              ph_nxt = delp_pkg::PH_IGNORE;
            end
          end
          delp_pkg::PH_FIRST_NUM, delp_pkg::PH_NEXT_NUM: begin
            if (digit) begin
              acc_nxt = (|prod[PW-1:ID_WIDTH]) ? acc_sat : prod[ID_WIDTH:0];
            end else begin
              push.edge_vld = fin_edge;
              if (fin_ok) begin
                prev_nxt = acc_id;
                max_nxt  = fin_max;
                seen_nxt = 1'b1;
                if (blank) begin
                  ph_nxt = delp_pkg::PH_AFTER_ID;
                end else if (ch == delp_pkg::CH_DASH) begin
                  ph_nxt = delp_pkg::PH_DASH;
                end else begin
                  ph_nxt = delp_pkg::PH_IGNORE;
                end
              end else begin
                ph_nxt = delp_pkg::PH_IGNORE;
              end
            end
          end
          delp_pkg::PH_AFTER_ID: begin
            if (!blank) begin
              ph_nxt = (ch == delp_pkg::CH_DASH) ? delp_pkg::PH_DASH : delp_pkg::PH_IGNORE;
            end
          end
          delp_pkg::PH_DASH: begin
            if (ch == delp_pkg::CH_GT || ch == delp_pkg::CH_DASH) begin
              if (!known_r) begin
                dir_nxt   = (ch == delp_pkg::CH_GT);
                known_nxt = 1'b1;
              end
              ph_nxt = delp_pkg::PH_PRE_NUM;
            end else begin
              ph_nxt = delp_pkg::PH_IGNORE;
            end
          end
          delp_pkg::PH_PRE_NUM: begin
            if (digit) begin
              acc_nxt = digit_val;
              ph_nxt  = delp_pkg::PH_NEXT_NUM;
            end else if (!blank) begin
              ph_nxt = delp_pkg::PH_IGNORE;
            end
          end
          default: ph_nxt = delp_pkg::PH_IGNORE;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ph_r       <= delp_pkg::PH_LEAD;
      kw_pos_r   <= '0;
      line_pos_r <= '0;
      acc_r      <= '0;
      prev_r     <= '0;
      max_r      <= '0;
      seen_r     <= 1'b0;
      dir_r      <= 1'b1;
      known_r    <= 1'b0;
    end else begin
      ph_r       <= ph_nxt;
      kw_pos_r   <= kw_nxt;
      line_pos_r <= lp_nxt;
      acc_r      <= acc_nxt;
      prev_r     <= prev_nxt;
      max_r      <= max_nxt;
      seen_r     <= seen_nxt;
      dir_r      <= dir_nxt;
      known_r    <= known_nxt;
    end
  end

endmodule

`default_nettype wire

@@ rtl/delp_checker.sv @@
// Port-level checker of the edge-list parser, bound to the top level.
// Depends on delp_pkg and dot_edge_list_parser_defines.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "dot_edge_list_parser_defines.svh"

module delp_checker #(
  parameter int ID_WIDTH = delp_pkg::ID_WIDTH_DEF
) (
  input wire logic                clk,
  input wire logic                rst_n,
  input wire logic                in_valid,
  input wire logic                in_ready,
  input wire logic                in_opcode,
  input wire logic                out_valid,
  input wire logic                out_ready,
  input wire logic                out_kind,
  input wire logic [ID_WIDTH-1:0] out_src_id,
  input wire logic [ID_WIDTH-1:0] out_dst_id,
  input wire logic                out_is_directed,
  input wire logic [ID_WIDTH:0]   out_vertex_count,
  input wire logic                out_valid_res,
  input wire logic                out_last
);

  `DELP_ASSERT_NEXT(a_end_gives_result, clk, rst_n,
    in_valid && in_ready && in_opcode == delp_pkg::OP_END, out_valid,
    "end request not followed by a result")

  `DELP_ASSERT_IMPL(a_summary_shape, clk, rst_n,
    out_valid && out_kind == delp_pkg::KIND_SUMMARY,
    out_last && out_src_id == '0 && out_dst_id == '0 && (out_valid_res || out_vertex_count == '0),
    "malformed summary")

  `DELP_ASSERT_IMPL(a_edge_shape, clk, rst_n,
    out_valid && out_kind == delp_pkg::KIND_EDGE,
    out_vertex_count == '0 && !out_valid_res,
    "malformed edge result")

  `DELP_ASSERT_NEXT(a_out_hold, clk, rst_n,
    out_valid && !out_ready,
    out_valid && $stable({out_kind, out_src_id, out_dst_id, out_is_directed, out_vertex_count, out_valid_res, out_last}),
    "stalled result changed")

endmodule

bind dot_edge_list_parser delp_checker #(
  .ID_WIDTH (ID_WIDTH)
) u_delp_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_ch.valid),
  .in_ready         (in_ch.ready),
  .in_opcode        (in_ch.opcode),
  .out_valid        (out_res.valid),
  .out_ready        (out_res.ready),
  .out_kind         (out_res.kind),
  .out_src_id       (out_res.src_id),
  .out_dst_id       (out_res.dst_id),
  .out_is_directed  (out_res.is_directed),
  .out_vertex_count (out_res.vertex_count),
  .out_valid_res    (out_res.valid_res),
  .out_last         (out_res.last)
);

`default_nettype wire

@@ sim/tb_dot_edge_list_parser.sv @@
// Self-checking bench for dot_edge_list_parser: random DOT edge-list text streams,
// an in-bench parser that predicts the edges and summaries, random stalls on both sides.
// Depends on delp_pkg, delp_in_if, delp_out_if and the dot_edge_list_parser RTL.
`timescale 1ns / 1ps

module tb_dot_edge_list_parser;

  localparam logic [24:0] ID_LIMIT  = 25'h0FF_FFFF;
  localparam int          LINE_KEEP = delp_pkg::LINE_BUFFER_DEF - 1;
  localparam int          IDLE_MAX  = 4000;
  localparam int          LONG_HOLD = 500;

  typedef struct {
    logic       op;
    logic [7:0] ch;
    bit         hold;
  } req_t;

  typedef struct packed {
    logic        kind;
    logic [23:0] src;
    logic [23:0] dst;
    logic        dir;
    logic [24:0] vcount;
    logic        vres;
    logic        last;
  } res_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  delp_in_if  in_ch();
  delp_out_if out_res();

  dot_edge_list_parser uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_res(out_res)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  req_t text_q[$];
  res_t pending_results[$];
  req_t cur_req;
  bit   hold_next;
  int   n_err;
  int   n_sent;

  // parser state of the prediction
  delp_pkg::phase_t p_phase;
  logic [2:0]       p_kw_pos;
  logic [9:0]       p_line_len;
  logic [24:0]      p_acc;
  logic [23:0]      p_prev;
  logic [23:0]      p_max;
  logic             p_seen;
  logic             p_dir;
  logic             p_dir_known;

  task automatic flag_error(string msg);
    $display("%0t ns mismatch: %s", $time, msg);
    n_err++;
  endtask

  task automatic check_field(string name, logic [31:0] got, logic [31:0] want);
    if (got !== want) flag_error($sformatf("%s got %0d want %0d", name, got, want));
  endtask

  function automatic bit blank_ch(logic [7:0] c);
    return c == 8'd32 || (c >= 8'd9 && c <= 8'd13);
  endfunction

  function automatic bit digit_ch(logic [7:0] c);
    return c >= 8'h30 && c <= 8'h39;
  endfunction

  task automatic clear_parser();
    p_phase     = delp_pkg::PH_LEAD;
    p_kw_pos    = 3'd0;
    p_line_len  = 10'd0;
    p_acc       = 25'd0;
    p_prev      = 24'd0;
    p_max       = 24'd0;
    p_seen      = 1'b0;
    p_dir       = 1'b1;
    p_dir_known = 1'b0;
  endtask

  task automatic finish_id();
    if (p_phase == delp_pkg::PH_FIRST_NUM || p_phase == delp_pkg::PH_NEXT_NUM) begin
      if (p_acc > ID_LIMIT) begin
        p_phase = delp_pkg::PH_IGNORE;
      end else begin
        if (!p_seen || p_acc[23:0] > p_max) p_max = p_acc[23:0];
        p_seen = 1'b1;
        if (p_phase == delp_pkg::PH_NEXT_NUM)
          pending_results.push_back('{delp_pkg::KIND_EDGE, p_prev, p_acc[23:0], p_dir,
                                      25'd0, 1'b0, 1'b0});
        p_prev  = p_acc[23:0];
        p_phase = delp_pkg::PH_AFTER_ID;
      end
    end
  endtask

  task automatic start_line(logic [7:0] c, bit after_strict);
    p_kw_pos = 3'd1;
    if (c == delp_pkg::CH_D) begin
      p_phase = delp_pkg::PH_DIGRAPH;
    end else if (c == delp_pkg::CH_G) begin
      p_phase = delp_pkg::PH_GRAPH;
    end else if (c == delp_pkg::CH_S && !after_strict) begin
      p_phase = delp_pkg::PH_STRICT;
    end else if (digit_ch(c)) begin
      p_acc   = 25'(c - 8'h30);
      p_phase = delp_pkg::PH_FIRST_NUM;
    end else begin
      p_phase = delp_pkg::PH_IGNORE;
    end
  endtask

  task automatic match_word(logic [7:0] c, string word, delp_pkg::phase_t done, int set_dir);
    if (p_kw_pos < word.len() && c == word[p_kw_pos]) begin
      p_kw_pos++;
      if (p_kw_pos == word.len()) begin
        if (set_dir >= 0) begin
          p_dir       = set_dir[0];
          p_dir_known = 1'b1;
        end
        p_phase = done;
      end
    end else begin
      p_phase = delp_pkg::PH_IGNORE;
    end
  endtask

  task automatic parse_request(req_t r);
    int          base;
    logic [31:0] t;
    base = pending_results.size();
    if (r.op == delp_pkg::OP_END) begin
      finish_id();
      pending_results.push_back('{delp_pkg::KIND_SUMMARY, 24'd0, 24'd0, p_dir,
                                  p_seen ? {1'b0, p_max} + 25'd1 : 25'd0, p_seen, 1'b0});
      clear_parser();
    end else if (r.ch == delp_pkg::CH_NL) begin
      finish_id();
      p_phase    = delp_pkg::PH_LEAD;
      p_line_len = 10'd0;
      p_kw_pos   = 3'd0;
    end else if (p_line_len >= LINE_KEEP || r.ch == delp_pkg::CH_NUL) begin
      finish_id();
      p_phase = delp_pkg::PH_IGNORE;
    end else begin
      p_line_len++;
      case (p_phase)
        delp_pkg::PH_LEAD: begin
          if (!blank_ch(r.ch)) start_line(r.ch, 1'b0);
        end
        delp_pkg::PH_STRICT:
          match_word(r.ch, "strict", delp_pkg::PH_POST_STRICT, -1);
        delp_pkg::PH_POST_STRICT: begin
          if (!blank_ch(r.ch)) start_line(r.ch, 1'b1);
        end
        delp_pkg::PH_DIGRAPH:
          match_word(r.ch, "digraph", delp_pkg::PH_IGNORE, 1);
        delp_pkg::PH_GRAPH:
          match_word(r.ch, "graph", delp_pkg::PH_IGNORE, 0);
        delp_pkg::PH_FIRST_NUM, delp_pkg::PH_NEXT_NUM: begin
          if (digit_ch(r.ch)) begin
            t = 32'(p_acc) * 32'd10 + 32'(r.ch - 8'h30);
            p_acc = (t > 32'(ID_LIMIT)) ? ID_LIMIT + 25'd1 : t[24:0];
          end else begin
            finish_id();
            if (p_phase == delp_pkg::PH_AFTER_ID && !blank_ch(r.ch))
              p_phase = (r.ch == delp_pkg::CH_DASH) ? delp_pkg::PH_DASH
                                                    : delp_pkg::PH_IGNORE;
          end
        end
        delp_pkg::PH_AFTER_ID: begin
          if (!blank_ch(r.ch))
            p_phase = (r.ch == delp_pkg::CH_DASH) ? delp_pkg::PH_DASH : delp_pkg::PH_IGNORE;
        end
        delp_pkg::PH_DASH: begin
          if (r.ch == delp_pkg::CH_GT || r.ch == delp_pkg::CH_DASH) begin
            if (!p_dir_known) begin
              p_dir       = (r.ch == delp_pkg::CH_GT);
              p_dir_known = 1'b1;
            end
            p_phase = delp_pkg::PH_PRE_NUM;
          end else begin
            p_phase = delp_pkg::PH_IGNORE;
          end
        end
        delp_pkg::PH_PRE_NUM: begin
          if (digit_ch(r.ch)) begin
            p_acc   = 25'(r.ch - 8'h30);
            p_phase = delp_pkg::PH_NEXT_NUM;
          end else if (!blank_ch(r.ch)) begin
            p_phase = delp_pkg::PH_IGNORE;
          end
        end
        default: p_phase = delp_pkg::PH_IGNORE;
      endcase
    end
    if (pending_results.size() > base) pending_results[$].last = 1'b1;
  endtask

  // stimulus text
  task automatic put_byte(logic [7:0] c);
    text_q.push_back('{delp_pkg::OP_CHAR, c, hold_next});
    hold_next = 1'b0;
  endtask

  task automatic put_text(string s);
    for (int i = 0; i < s.len(); i++) put_byte(s[i]);
  endtask

  task automatic add_end();
    text_q.push_back('{delp_pkg::OP_END, 8'($urandom_range(0, 255)), hold_next});
    hold_next = 1'b0;
  endtask

  function automatic logic [7:0] pick_blank();
    case ($urandom_range(0, 4))
      0:       return 8'd9;
      1:       return 8'd11;
      2:       return 8'd12;
      3:       return 8'd13;
      default: return delp_pkg::CH_SPACE;
    endcase
  endfunction

  function automatic string id_text();
    int    r;
    string s;
    r = $urandom_range(0, 99);
    if (r < 50) begin
      s = $sformatf("%0d", $urandom_range(0, 30));
    end else if (r < 70) begin
      s = $sformatf("%0d", $urandom_range(0, 999));
    end else if (r < 84) begin
      s = $sformatf("%0d", $urandom_range(0, 24'hFF_FFFF));
    end else if (r < 89) begin
      s = "16777215";
    end else if (r < 93) begin
      s = $sformatf("%0d", 16777216 + $urandom_range(0, 9999));
    end else if (r < 96) begin
      s = "";
      repeat ($urandom_range(9, 12)) s = {s, $sformatf("%0d", $urandom_range(0, 9))};
    end else begin
      s = {"00", $sformatf("%0d", $urandom_range(0, 99))};
    end
    return s;
  endfunction

  task automatic add_chain_line(bit newline);
    repeat ($urandom_range(0, 2)) put_byte(pick_blank());
    put_text(id_text());
    repeat ($urandom_range(0, 4)) begin
      if ($urandom_range(0, 3) == 0) put_byte(pick_blank());
      put_byte(delp_pkg::CH_DASH);
      put_byte($urandom_range(0, 1) ? delp_pkg::CH_GT : delp_pkg::CH_DASH);
      if ($urandom_range(0, 3) == 0) put_byte(pick_blank());
      put_text(id_text());
    end
    case ($urandom_range(0, 15))
      0: begin
        put_byte(delp_pkg::CH_NUL);
        put_byte(8'($urandom_range(0, 255)));
      end
      1:       put_text("->");
      2:       put_byte(8'($urandom_range(0, 255)));
      3:       put_text(" -x 4");
      default: ;
    endcase
    if (newline) put_byte(delp_pkg::CH_NL);
  endtask

  task automatic add_keyword_line();
    repeat ($urandom_range(0, 1)) put_byte(pick_blank());
    if ($urandom_range(0, 2) == 0) begin
      put_text("strict");
      repeat ($urandom_range(0, 2)) put_byte(pick_blank());
    end
    case ($urandom_range(0, 7))
      0:       put_text("digraph");
      1:       put_text("graph");
      2:       put_text("digraph G {");
      3:       put_text("graph {");
      4:       put_text("digrapx");
      5:       put_text("graphs");
      6:       put_text("9->8");
      default: put_text("sx");
    endcase
    put_byte(delp_pkg::CH_NL);
  endtask

  task automatic add_comment_line();
    case ($urandom_range(0, 6))
      0:       put_text("# x");
      1:       put_text("% 1->2");
      2:       put_text("// 3->4");
      3:       put_text("{");
      4:       put_text("}");
      5:       put_text("/3");
      default: ;
    endcase
    put_byte(delp_pkg::CH_NL);
  endtask

  task automatic add_stream();
    int n_lines;
    int r;
    if ($urandom_range(0, 1)) add_keyword_line();
    n_lines = $urandom_range(2, 12);
    for (int i = 0; i < n_lines; i++) begin
      r = $urandom_range(0, 19);
      if (r < 12) begin
        add_chain_line(i != n_lines - 1 || $urandom_range(0, 3) != 0);
      end else if (r < 14) begin
        add_keyword_line();
      end else if (r < 17) begin
        add_comment_line();
      end else begin
        repeat ($urandom_range(1, 16)) put_byte(8'($urandom_range(0, 255)));
        put_byte(delp_pkg::CH_NL);
      end
    end
    add_end();
  endtask

  function automatic int pick_gap(bit calm);
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // request driver
  int drv_gap;
  bit drv_calm;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid  <= 1'b0;
      in_ch.opcode <= delp_pkg::OP_CHAR;
      in_ch.ch     <= 8'd0;
      drv_gap = 0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        parse_request(cur_req);
        n_sent++;
      end
      if (!in_ch.valid || in_ch.ready) begin
        if (drv_gap > 0) begin
          drv_gap--;
          in_ch.valid <= 1'b0;
        end else if (text_q.size() > 0 && !(text_q[0].hold && pending_results.size() > 0)) begin
          cur_req = text_q.pop_front();
          in_ch.valid  <= 1'b1;
          in_ch.opcode <= cur_req.op;
          in_ch.ch     <= cur_req.ch;
          drv_gap = pick_gap(drv_calm);
          if ($urandom_range(0, 149) == 0) drv_calm = !drv_calm;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // result monitor
  int   mon_gap;
  bit   mon_calm;
  bit   long_done;
  int   long_left;
  res_t got;
  res_t want;

  always @(posedge clk) begin
    if (!rst_n) begin
      out_res.ready <= 1'b0;
      mon_gap = 0;
    end else begin
      if (out_res.valid && out_res.ready) begin
        got = '{out_res.kind, out_res.src_id, out_res.dst_id, out_res.is_directed,
                out_res.vertex_count, out_res.valid_res, out_res.last};
        if (pending_results.size() == 0) begin
          flag_error($sformatf("unexpected result kind %0d src %0d dst %0d",
                               got.kind, got.src, got.dst));
        end else begin
          want = pending_results.pop_front();
          check_field("kind", got.kind, want.kind);
          check_field("src_id", got.src, want.src);
          check_field("dst_id", got.dst, want.dst);
          check_field("is_directed", got.dir, want.dir);
          check_field("vertex_count", got.vcount, want.vcount);
          check_field("valid_res", got.vres, want.vres);
          check_field("last", got.last, want.last);
        end
      end
      if (!long_done && n_sent >= 400) begin
        long_done = 1'b1;
        long_left = LONG_HOLD;
      end
      if (long_left > 0) begin
        long_left--;
        out_res.ready <= 1'b0;
      end else if (mon_gap > 0) begin
        mon_gap--;
        out_res.ready <= 1'b0;
      end else begin
        out_res.ready <= 1'b1;
        mon_gap = pick_gap(mon_calm);
        if ($urandom_range(0, 149) == 0) mon_calm = !mon_calm;
      end
    end
  end

  // watchdog on cycles without any handshake
  int idle_cycles;

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_ch.valid && in_ch.ready) || (out_res.valid && out_res.ready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= IDLE_MAX) begin
        $display("tb: failure");
        $finish;
      end
    end
  end

  initial begin
    in_ch.valid   = 1'b0;
    in_ch.opcode  = delp_pkg::OP_CHAR;
    in_ch.ch      = 8'd0;
    out_res.ready = 1'b0;
    clear_parser();

    put_text("0->16777215--7\n");
    put_text("\t12 -- 3 -> x\n");
    put_text("5");
    put_byte(delp_pkg::CH_NUL);
    put_text(" 9\n");
    put_text("16777216->1\n");
    put_text("strict graph {\n");
    put_text("4--\n");
    put_text("44");
    add_end();

    hold_next = 1'b1;
    while (text_q.size() < 900) begin
      if ($urandom_range(0, 9) == 0) hold_next = 1'b1;
      add_stream();
    end

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    while (text_q.size() > 0 || in_ch.valid) @(posedge clk);
    while (pending_results.size() > 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (pending_results.size() != 0)
      flag_error($sformatf("%0d results never arrived", pending_results.size()));
    if (n_err == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
